// ----- design/acr_pkg.sv -----
// ---------------------------------------------------------------------------
// acr_pkg
// Types, codes and helpers shared by the acknowledged event count reporter.
// ---------------------------------------------------------------------------
package acr_pkg;

  localparam int COUNT_W = 16;
  localparam int SEQ_W   = 16;
  localparam int MISS_W  = 8;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [MISS_W-1:0] MISS_THRESHOLD_RST = MISS_W'(10);

  // Item kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_TRIGGER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_THRESHOLD = 1'b1;

  // Input item: tdata = link_up, send_accepted, ack_count, ack_seq (+ zero fill)
  localparam int IN_DATA_BITS = 2 + COUNT_W + SEQ_W;
  localparam int IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;

  // Result item fields, lowest bits first
  localparam int OUT_DATA_BITS = COUNT_W + 1 + COUNT_W + SEQ_W + 2;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [SEQ_W-1:0]   ack_seq;
    logic [COUNT_W-1:0] ack_count;
    logic               send_accepted;
    logic               link_up;
    logic [REQ_W-1:0]   req_type;
  } in_item_t;

  typedef struct packed {
    logic               requeued;
    logic               clear_notify;
    logic [SEQ_W-1:0]   report_seq;
    logic [COUNT_W-1:0] report_count;
    logic               report_valid;
    logic [COUNT_W-1:0] display_count;
  } out_item_t;

  // Handshake between the input register and the result register
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage

// ----- design/acr_in_stage.sv -----
// ---------------------------------------------------------------------------
// acr_in_stage
// Input register: holds one accepted item until the core consumes it.
// ---------------------------------------------------------------------------
module acr_in_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [acr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [acr_pkg::REQ_W-1:0]        in_tuser,
  input  logic                             advance,
  output logic                             item_valid,
  output acr_pkg::in_item_t                item
);

  logic              valid_r;
  logic              valid_nxt;
  acr_pkg::in_item_t item_r;
  logic              load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.req_type      <= in_tuser;
      item_r.link_up       <= in_tdata[0];
      item_r.send_accepted <= in_tdata[1];
      item_r.ack_count     <= in_tdata[2 +: acr_pkg::COUNT_W];
      item_r.ack_seq       <= in_tdata[2 + acr_pkg::COUNT_W +: acr_pkg::SEQ_W];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- design/acr_core.sv -----
// ---------------------------------------------------------------------------
// acr_core
// Count state, configuration registers and the per-item update logic.
// ---------------------------------------------------------------------------
module acr_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [acr_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [acr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              step,
  input  acr_pkg::in_item_t                 item,
  output acr_pkg::out_item_t                result
);

  logic                         count_enable_r;
  logic [acr_pkg::MISS_W-1:0]   miss_threshold_r;
  logic [acr_pkg::COUNT_W-1:0]  pending_r, pending_nxt;
  logic [acr_pkg::COUNT_W-1:0]  sent_r, sent_nxt;
  logic [acr_pkg::COUNT_W-1:0]  acked_r, acked_nxt;
  logic [acr_pkg::SEQ_W-1:0]    next_seq_r, next_seq_nxt;
  logic [acr_pkg::MISS_W-1:0]   miss_r, miss_nxt;
  logic [acr_pkg::MISS_W-1:0]   miss_inc;
  logic [acr_pkg::SEQ_W-1:0]    last_seq;
  acr_pkg::out_item_t           res;

  assign last_seq = next_seq_r - acr_pkg::SEQ_W'(1);
  assign miss_inc = (miss_r == {acr_pkg::MISS_W{1'b1}}) ? miss_r
                                                        : miss_r + acr_pkg::MISS_W'(1);

  always_comb begin
    pending_nxt  = pending_r;
    sent_nxt     = sent_r;
    acked_nxt    = acked_r;
    next_seq_nxt = next_seq_r;
    miss_nxt     = miss_r;
    res          = '0;
    unique case (item.req_type)
      acr_pkg::REQ_TRIGGER: begin
        if (count_enable_r) begin
          pending_nxt = acr_pkg::sat_add(pending_r, acr_pkg::COUNT_W'(1));
        end
      end
      acr_pkg::REQ_TICK: begin
        if (count_enable_r && pending_r != '0 && item.link_up) begin
          if (sent_r == '0) begin
            res.report_valid = 1'b1;
            res.report_count = pending_r;
            res.report_seq   = next_seq_r;
            if (item.send_accepted) begin
              next_seq_nxt = next_seq_r + acr_pkg::SEQ_W'(1);
              sent_nxt     = pending_r;
              pending_nxt  = '0;
            end
          end else begin
            miss_nxt = miss_inc;
            // Threshold reached: the unacknowledged report goes back to pending.
            if (miss_inc >= miss_threshold_r) begin
              pending_nxt  = acr_pkg::sat_add(pending_r, sent_r);
              sent_nxt     = '0;
              miss_nxt     = '0;
              res.requeued = 1'b1;
            end
          end
        end
      end
      acr_pkg::REQ_ACK: begin
        if (item.ack_seq == last_seq && item.ack_count == sent_r) begin
          acked_nxt = acr_pkg::sat_add(acked_r, sent_r);
          sent_nxt  = '0;
          miss_nxt  = '0;
        end
      end
      acr_pkg::REQ_CLEAR: begin
        pending_nxt      = '0;
        sent_nxt         = '0;
        acked_nxt        = '0;
        res.clear_notify = item.link_up;
      end
      default: begin
      end
    endcase
    res.display_count = acr_pkg::sat_add(acr_pkg::sat_add(pending_nxt, sent_nxt), acked_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_enable_r   <= 1'b0;
      miss_threshold_r <= acr_pkg::MISS_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acr_pkg::CFG_COUNT_ENABLE:   count_enable_r   <= cfg_wdata[0];
        acr_pkg::CFG_MISS_THRESHOLD: miss_threshold_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      sent_r     <= '0;
      acked_r    <= '0;
      next_seq_r <= '0;
      miss_r     <= '0;
    end else if (step) begin
      pending_r  <= pending_nxt;
      sent_r     <= sent_nxt;
      acked_r    <= acked_nxt;
      next_seq_r <= next_seq_nxt;
      miss_r     <= miss_nxt;
    end
  end

  assign result = res;

endmodule

// ----- design/acr_out_stage.sv -----
// ---------------------------------------------------------------------------
// acr_out_stage
// Result register: holds a finished item until the downstream side takes it.
// ---------------------------------------------------------------------------
module acr_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  acr_pkg::out_item_t               result,
  output acr_pkg::stage_ctrl_t             ctrl,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [acr_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic               valid_r;
  logic               valid_nxt;
  acr_pkg::out_item_t data_r;
  logic               advance;

  // A new result may enter when the register is empty or being drained.
  assign advance = item_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= result;
    end
  end

  assign ctrl.valid   = valid_r;
  assign ctrl.advance = advance;
  assign out_tvalid   = valid_r;
  assign out_tdata    = acr_pkg::OUT_DATA_W'(data_r);

endmodule

// ----- design/acked_event_count_reporter.sv -----
// ---------------------------------------------------------------------------
// acked_event_count_reporter
// Counts sensor triggers and reports them to a host until acknowledged.
// ---------------------------------------------------------------------------
// Each item (trigger, tick, acknowledgement or clear) yields exactly one
// result item. An accepted item sits in an input register, goes through the
// update logic against the count state and lands in a result register,
// which drives out_tvalid; the move waits while an earlier result there has
// not been taken. With out_tready high one item is accepted every cycle.
// While a result waits with out_tready low, the next item holds in the input
// register, and once that register is full in_tready drops until the result
// is taken. Configuration writes are taken at any time but should only be
// made while no item is in flight.
module acked_event_count_reporter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [acr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [acr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // link_up, send_accepted, ack_count[15:0], ack_seq[15:0], zero fill
  input  logic [acr_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type[1:0]
  input  logic [acr_pkg::REQ_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // display_count[15:0], report_valid, report_count[15:0], report_seq[15:0],
  // clear_notify, requeued, zero fill
  output logic [acr_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic                 item_valid;
  acr_pkg::in_item_t    item;
  acr_pkg::out_item_t   result;
  acr_pkg::stage_ctrl_t ctrl;

  acr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (ctrl.advance),
    .item_valid (item_valid),
    .item       (item)
  );

  acr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (ctrl.advance),
    .item      (item),
    .result    (result)
  );

  acr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .ctrl       (ctrl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- sim/acked_event_count_reporter_test.sv -----
// ---------------------------------------------------------------------------
// acked_event_count_reporter_test
// Self-checking bench for the acknowledged event count reporter. Items are
// driven on the input stream from a queue, every accepted item is run through
// a local copy of the count state to get the result it should give, and each
// result item is checked field by field against the oldest such prediction.
// Runs go through several enable and miss threshold settings, with the
// sender and receiver idling in different proportions.
// ---------------------------------------------------------------------------
module acked_event_count_reporter_test;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_SHOWN   = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    acr_pkg::in_item_t it;
    bit                fill_ack;   // take ack fields from the live count state
    logic [31:0]       flip;       // bits inverted in a filled acknowledgement
  } queued_item_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [acr_pkg::CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [acr_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [acr_pkg::IN_DATA_W-1:0]   in_tdata   = '0;
  logic [acr_pkg::REQ_W-1:0]       in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [acr_pkg::OUT_DATA_W-1:0]  out_tdata;

  acked_event_count_reporter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queued_item_t       stim_q[$];
  acr_pkg::out_item_t expected_q[$];
  idle_mode_t         idle_mode = IDLE_NONE;
  logic               in_took   = 1'b0;
  int                 errors    = 0;
  int                 stall_run = 0;

  // Local copy of the configuration and the count state.
  logic                        enable_m = 1'b0;
  logic [acr_pkg::MISS_W-1:0]  thresh_m = acr_pkg::MISS_THRESHOLD_RST;
  logic [acr_pkg::COUNT_W-1:0] cnt_pending = '0;
  logic [acr_pkg::COUNT_W-1:0] cnt_sent    = '0;
  logic [acr_pkg::COUNT_W-1:0] cnt_acked   = '0;
  logic [acr_pkg::SEQ_W-1:0]   seq_next    = '0;
  logic [acr_pkg::MISS_W-1:0]  miss_run    = '0;

  function automatic logic [acr_pkg::COUNT_W-1:0] add_clamped(
      logic [acr_pkg::COUNT_W-1:0] a, logic [acr_pkg::COUNT_W-1:0] b);
    logic [acr_pkg::COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[acr_pkg::COUNT_W] ? {acr_pkg::COUNT_W{1'b1}} : s[acr_pkg::COUNT_W-1:0];
  endfunction

  task automatic apply_item(input acr_pkg::in_item_t it, output acr_pkg::out_item_t res);
    res = '0;
    case (it.req_type)
      acr_pkg::REQ_TRIGGER: begin
        if (enable_m) cnt_pending = add_clamped(cnt_pending, acr_pkg::COUNT_W'(1));
      end
      acr_pkg::REQ_TICK: begin
        if (enable_m && cnt_pending != '0 && it.link_up) begin
          if (cnt_sent == '0) begin
            res.report_valid = 1'b1;
            res.report_count = cnt_pending;
            res.report_seq   = seq_next;
            if (it.send_accepted) begin
              seq_next    = seq_next + acr_pkg::SEQ_W'(1);
              cnt_sent    = cnt_pending;
              cnt_pending = '0;
            end
          end else begin
            if (miss_run != {acr_pkg::MISS_W{1'b1}})
              miss_run = miss_run + acr_pkg::MISS_W'(1);
            if (miss_run >= thresh_m) begin
              cnt_pending  = add_clamped(cnt_pending, cnt_sent);
              cnt_sent     = '0;
              miss_run     = '0;
              res.requeued = 1'b1;
            end
          end
        end
      end
      acr_pkg::REQ_ACK: begin
        // The host acknowledges the sequence number of the last report sent.
        if (it.ack_seq == acr_pkg::SEQ_W'(seq_next - acr_pkg::SEQ_W'(1)) &&
            it.ack_count == cnt_sent) begin
          cnt_acked = add_clamped(cnt_acked, cnt_sent);
          cnt_sent  = '0;
          miss_run  = '0;
        end
      end
      acr_pkg::REQ_CLEAR: begin
        cnt_pending      = '0;
        cnt_sent         = '0;
        cnt_acked        = '0;
        res.clear_notify = it.link_up;
      end
      default: ;
    endcase
    res.display_count = add_clamped(add_clamped(cnt_pending, cnt_sent), cnt_acked);
  endtask

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_rests();
    return (idle_mode == IDLE_SEND && chance(60)) || (idle_mode == IDLE_BOTH && chance(15));
  endfunction

  function automatic bit receiver_stalls();
    return (idle_mode == IDLE_RECV && chance(60)) || (idle_mode == IDLE_BOTH && chance(15));
  endfunction

  // Input side: a new item goes out once the previous one has been taken.
  always @(negedge clk) begin : item_driver
    queued_item_t                nx;
    logic [acr_pkg::COUNT_W-1:0] a_cnt;
    logic [acr_pkg::SEQ_W-1:0]   a_seq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (stim_q.size() != 0 && !sender_rests()) begin
        nx    = stim_q.pop_front();
        a_cnt = nx.it.ack_count;
        a_seq = nx.it.ack_seq;
        // Everything accepted so far is already in the local state here.
        if (nx.fill_ack) begin
          a_cnt = cnt_sent ^ nx.flip[acr_pkg::COUNT_W-1:0];
          a_seq = acr_pkg::SEQ_W'(seq_next - acr_pkg::SEQ_W'(1)) ^
                  nx.flip[16 +: acr_pkg::SEQ_W];
        end
        in_tvalid <= 1'b1;
        in_tuser  <= nx.it.req_type;
        in_tdata  <= acr_pkg::IN_DATA_W'({a_seq, a_cnt, nx.it.send_accepted,
                                          nx.it.link_up});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= !receiver_stalls();
  end

  always @(posedge clk) begin : result_monitor
    acr_pkg::in_item_t  seen;
    acr_pkg::out_item_t want;
    acr_pkg::out_item_t got;
    in_took <= in_tvalid && in_tready;
    if (!rst_n) begin
      stall_run <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          acr_pkg::CFG_COUNT_ENABLE:   enable_m = cfg_wdata[0];
          acr_pkg::CFG_MISS_THRESHOLD: thresh_m = cfg_wdata[acr_pkg::MISS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        seen.req_type      = in_tuser;
        seen.link_up       = in_tdata[0];
        seen.send_accepted = in_tdata[1];
        seen.ack_count     = in_tdata[2 +: acr_pkg::COUNT_W];
        seen.ack_seq       = in_tdata[2 + acr_pkg::COUNT_W +: acr_pkg::SEQ_W];
        apply_item(seen, want);
        expected_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = acr_pkg::out_item_t'(out_tdata[acr_pkg::OUT_DATA_BITS-1:0]);
        if (expected_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= MAX_SHOWN)
            $display("unexpected result item: display=%0d report=%0b/%0d/%0d ",
                     got.display_count, got.report_valid, got.report_count,
                     got.report_seq, "notify=%0b requeue=%0b",
                     got.clear_notify, got.requeued);
        end else begin
          want = expected_q.pop_front();
          if (got.display_count !== want.display_count ||
              got.report_valid  !== want.report_valid  ||
              got.report_count  !== want.report_count  ||
              got.report_seq    !== want.report_seq    ||
              got.clear_notify  !== want.clear_notify  ||
              got.requeued      !== want.requeued) begin
            errors = errors + 1;
            if (errors <= MAX_SHOWN)
              $display("mismatch: expected display=%0d report=%0b/%0d/%0d ",
                       want.display_count, want.report_valid, want.report_count,
                       want.report_seq, "notify=%0b requeue=%0b, ",
                       want.clear_notify, want.requeued,
                       "got display=%0d report=%0b/%0d/%0d ",
                       got.display_count, got.report_valid, got.report_count,
                       got.report_seq, "notify=%0b requeue=%0b",
                       got.clear_notify, got.requeued);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stall_run <= 0;
      else
        stall_run <= stall_run + 1;
    end
  end

  initial begin : watchdog
    wait (stall_run >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_item(logic [acr_pkg::REQ_W-1:0] req, bit link, bit acc,
                           logic [acr_pkg::COUNT_W-1:0] a_cnt,
                           logic [acr_pkg::SEQ_W-1:0] a_seq,
                           bit fill = 1'b0, logic [31:0] flip = '0);
    queued_item_t q;
    q.it.req_type      = req;
    q.it.link_up       = link;
    q.it.send_accepted = acc;
    q.it.ack_count     = a_cnt;
    q.it.ack_seq       = a_seq;
    q.fill_ack         = fill;
    q.flip             = flip;
    stim_q.push_back(q);
  endtask

  task automatic push_noise();
    push_item(acr_pkg::REQ_W'($urandom), 1'($urandom), 1'($urandom),
              acr_pkg::COUNT_W'($urandom), acr_pkg::SEQ_W'($urandom));
  endtask

  // Trigger, tick or clear with random content in the fields it ignores.
  task automatic push_plain(logic [acr_pkg::REQ_W-1:0] req, bit link, bit acc);
    push_item(req, link, acc, acr_pkg::COUNT_W'($urandom), acr_pkg::SEQ_W'($urandom));
  endtask

  // Wait until nothing is queued, in flight or expected.
  task automatic drain();
    while (stim_q.size() != 0 || in_tvalid || expected_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [acr_pkg::CFG_IDX_W-1:0] idx,
                           logic [acr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(bit en, logic [acr_pkg::MISS_W-1:0] thr);
    drain();
    cfg_write(acr_pkg::CFG_COUNT_ENABLE, {7'($urandom), en});
    cfg_write(acr_pkg::CFG_MISS_THRESHOLD, thr);
  endtask

  // One report round: triggers, a send attempt, missed ticks, then an ending, or at times one random item.
  task automatic push_round(logic [acr_pkg::MISS_W-1:0] thr, ref int n);
    int k;
    int ending;
    if (chance(15)) begin
      push_noise();
      n = n + 1;
      return;
    end
    k = chance(20) ? $urandom_range(1, 8) : $urandom_range(1, 3);
    repeat (k) push_plain(acr_pkg::REQ_TRIGGER, 1'($urandom), 1'($urandom));
    n = n + k;
    push_plain(acr_pkg::REQ_TICK, !chance(12), !chance(25));
    n = n + 1;
    k = chance(17) ? $urandom_range(0, int'(thr) + 2) : $urandom_range(0, 3);
    repeat (k) begin
      if (chance(10)) push_plain(acr_pkg::REQ_TRIGGER, 1'($urandom), 1'($urandom));
      else push_plain(acr_pkg::REQ_TICK, !chance(10), 1'($urandom));
    end
    n = n + k;
    ending = $urandom_range(9);
    if (ending < 6)
      push_item(acr_pkg::REQ_ACK, 1'($urandom), 1'($urandom), '0, '0, 1'b1);
    else if (ending == 6)
      push_item(acr_pkg::REQ_ACK, 1'($urandom), 1'($urandom), '0, '0, 1'b1,
                32'(1) << $urandom_range(31));
    else if (ending == 7)
      push_plain(acr_pkg::REQ_CLEAR, 1'($urandom), 1'($urandom));
    else if (ending == 8)
      push_item(acr_pkg::REQ_ACK, 1'($urandom), 1'($urandom),
                acr_pkg::COUNT_W'($urandom), acr_pkg::SEQ_W'($urandom));
    n = n + ((ending == 9) ? 0 : 1);
  endtask

  task automatic random_phase(bit en, logic [acr_pkg::MISS_W-1:0] thr,
                              idle_mode_t mode, int target);
    int n;
    set_config(en, thr);
    idle_mode = mode;
    n = 0;
    while (n < target) push_round(thr, n);
  endtask

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Registers still at their reset values: counting is off.
    idle_mode = IDLE_NONE;
    push_plain(acr_pkg::REQ_TRIGGER, 1'b1, 1'b1);
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);
    push_item(acr_pkg::REQ_ACK, 1'b0, 1'b0, '0, {acr_pkg::SEQ_W{1'b1}});
    push_plain(acr_pkg::REQ_CLEAR, 1'b1, 1'b0);

    set_config(1'b1, acr_pkg::MISS_W'(2));
    push_plain(acr_pkg::REQ_TRIGGER, 1'b0, 1'b0);
    push_plain(acr_pkg::REQ_TRIGGER, 1'b1, 1'b1);
    push_plain(acr_pkg::REQ_TICK, 1'b0, 1'b1);         // link down
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b0);         // report refused
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);         // report taken
    push_plain(acr_pkg::REQ_TRIGGER, 1'b0, 1'b0);
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);         // first miss
    push_item(acr_pkg::REQ_ACK, 1'b1, 1'b1, acr_pkg::COUNT_W'(2), acr_pkg::SEQ_W'(5));
    push_item(acr_pkg::REQ_ACK, 1'b1, 1'b1, acr_pkg::COUNT_W'(3), acr_pkg::SEQ_W'(0));
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b0);         // threshold reached
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);
    push_item(acr_pkg::REQ_ACK, 1'b0, 1'b0, '0, '0, 1'b1);
    push_item(acr_pkg::REQ_ACK, 1'b1, 1'b1, {acr_pkg::COUNT_W{1'b1}},
              {acr_pkg::SEQ_W{1'b1}});
    push_plain(acr_pkg::REQ_CLEAR, 1'b0, 1'b1);
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);         // nothing pending
    push_plain(acr_pkg::REQ_TRIGGER, 1'b1, 1'b1);
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);
    push_plain(acr_pkg::REQ_CLEAR, 1'b1, 1'b1);        // drops the sent count
    push_plain(acr_pkg::REQ_TRIGGER, 1'b0, 1'b0);
    push_plain(acr_pkg::REQ_TICK, 1'b1, 1'b1);

    random_phase(1'b1, acr_pkg::MISS_W'(10),  IDLE_NONE, 300);
    random_phase(1'b1, acr_pkg::MISS_W'(1),   IDLE_SEND, 300);
    random_phase(1'b1, acr_pkg::MISS_W'(255), IDLE_RECV, 250);
    random_phase(1'b0, acr_pkg::MISS_W'(3),   IDLE_BOTH, 200);
    random_phase(1'b1, acr_pkg::MISS_W'(0),   IDLE_BOTH, 250);
    random_phase(1'b1, acr_pkg::MISS_W'($urandom_range(1, 20)), IDLE_SEND, 250);
    random_phase(1'b1, acr_pkg::MISS_W'($urandom_range(2, 6)),  IDLE_RECV, 200);
    random_phase(1'b1, acr_pkg::MISS_W'(4),   IDLE_BOTH, 100);

    drain();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/acr_pkg.sv
design/acr_in_stage.sv
design/acr_core.sv
design/acr_out_stage.sv
design/acked_event_count_reporter.sv
sim/acked_event_count_reporter_test.sv
